// ===== hw/rtl/via_pkg.sv =====
// Shared types and constants for the versatile interface adapter.
// Holds the transaction payload structs, operation codes and register numbers.
// No dependencies.
`default_nettype none

package via_pkg;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_TICK   = 3'd2,
        OP_PINS_A = 3'd3,
        OP_PINS_B = 3'd4,
        OP_CA1    = 3'd5,
        OP_CB1    = 3'd6
    } op_t;

    // Bus register numbers, standard adapter order
    localparam logic [3:0] REG_ORB    = 4'd0;
    localparam logic [3:0] REG_ORA    = 4'd1;
    localparam logic [3:0] REG_DDRB   = 4'd2;
    localparam logic [3:0] REG_DDRA   = 4'd3;
    localparam logic [3:0] REG_T1CL   = 4'd4;
    localparam logic [3:0] REG_T1CH   = 4'd5;
    localparam logic [3:0] REG_T1LL   = 4'd6;
    localparam logic [3:0] REG_T1LH   = 4'd7;
    localparam logic [3:0] REG_T2CL   = 4'd8;
    localparam logic [3:0] REG_T2CH   = 4'd9;
    localparam logic [3:0] REG_SR     = 4'd10;
    localparam logic [3:0] REG_ACR    = 4'd11;
    localparam logic [3:0] REG_PCR    = 4'd12;
    localparam logic [3:0] REG_IFR    = 4'd13;
    localparam logic [3:0] REG_IER    = 4'd14;
    localparam logic [3:0] REG_ORA_NH = 4'd15;

    // Interrupt flag bits
    localparam logic [6:0] FLAG_CA2 = 7'h01;
    localparam logic [6:0] FLAG_CA1 = 7'h02;
    localparam logic [6:0] FLAG_CB2 = 7'h08;
    localparam logic [6:0] FLAG_CB1 = 7'h10;
    localparam logic [6:0] FLAG_T2  = 7'h20;
    localparam logic [6:0] FLAG_T1  = 7'h40;

    // Manual control line modes in the peripheral control register
    localparam logic [2:0] CTL_MANUAL_LOW  = 3'b110;
    localparam logic [2:0] CTL_MANUAL_HIGH = 3'b111;

    localparam int unsigned CNT_W = 18;

    typedef struct packed {
        op_t        op;
        logic [3:0] reg_index;
        logic [7:0] data_value;
        logic [7:0] tick_cycles;
    } req_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
        logic       ca2_out;
        logic       cb2_out;
    } rsp_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/via_if.sv =====
// Valid/ready channel interfaces for the versatile interface adapter.
// Depends on via_pkg for the payload structs.
`default_nettype none

interface via_req_if
    import via_pkg::*;
;
    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface via_rsp_if
    import via_pkg::*;
;
    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/versatile_interface_adapter_top.sv =====
// Versatile interface adapter: register file, ports, timers and interrupt logic.
// Depends on via_pkg and the channel interfaces in via_if.sv.
//
// Usage:
//   req carries one transaction per item: a bus read or write of one of the
//   sixteen registers, a timer tick of tick_cycles clocks, new port A or B pin
//   levels, or a new CA1/CB1 level in bit zero of data_value.
//   rsp carries exactly one transaction per request: read data (zero unless
//   a read), the irq line and the port pin and CA2/CB2 levels after the item.
// Pipeline: an accepted request lands in the input register, is processed
//   there by the state update and its response is registered in the
//   response register, from which rsp offers it until it is taken.
// Throughput: one item per cycle unless rsp stalls, set by the single-pass
//   update of the register state between the input and response registers.
// Reset: asynchronous, active low; both pipeline registers empty, pins and
//   input latches all ones, every other state register zero; payloads unreset.
// Stall: while rsp is not taken the response holds; the input register
//   still fills, then req.ready drops until the response moves on.
`default_nettype none

module versatile_interface_adapter_top
    import via_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    via_req_if.sink    req,
    via_rsp_if.source  rsp
);

    // Pipeline registers
    logic      s1_valid_reg;
    req_item_t s1_item_reg;
    logic      rsp_valid_reg;
    rsp_item_t rsp_item_reg;
    logic      advance;

    // Architectural state
    logic [7:0]              pins_a_reg, pins_a_next;
    logic [7:0]              pins_b_reg, pins_b_next;
    logic [7:0]              latch_a_reg, latch_a_next;
    logic [7:0]              latch_b_reg, latch_b_next;
    logic [7:0]              ora_reg, ora_next;
    logic [7:0]              orb_reg, orb_next;
    logic [7:0]              ddra_reg, ddra_next;
    logic [7:0]              ddrb_reg, ddrb_next;
    logic signed [CNT_W-1:0] count_one_reg, count_one_next;
    logic [15:0]             reload_one_reg, reload_one_next;
    logic signed [CNT_W-1:0] count_two_reg, count_two_next;
    logic [7:0]              reload_two_low_reg, reload_two_low_next;
    logic                    fired_one_reg, fired_one_next;
    logic                    fired_two_reg, fired_two_next;
    logic [6:0]              flags_reg, flags_next;
    logic [6:0]              enables_reg, enables_next;
    logic [7:0]              acr_reg, acr_next;
    logic [7:0]              pcr_reg, pcr_next;
    logic [7:0]              sr_reg, sr_next;
    logic                    ca1_now_reg, ca1_now_next;
    logic                    ca1_before_reg, ca1_before_next;
    logic                    cb1_now_reg, cb1_now_next;
    logic                    cb1_before_reg, cb1_before_next;
    logic                    ca2_reg, ca2_next;
    logic                    cb2_reg, cb2_next;
    logic [7:0]              read_data;

    // Timer arithmetic, two bits of headroom below the floor
    localparam logic signed [CNT_W+1:0] CNT_FLOOR = -(20'sd131072);
    localparam logic signed [CNT_W+1:0] T1_WRAP   = 20'sd65535;
    localparam logic signed [CNT_W+1:0] T1_EXTRA  = 20'sd2;

    logic signed [CNT_W+1:0] t1_diff;
    logic signed [CNT_W+1:0] t2_diff;
    logic                    t1_due;
    logic                    t2_due;

    // Advance the input register into the response register when it is free
    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_item_reg;

    // Timer 1: count down, clamp at the floor, then reload, fire or wrap
    always_comb
    begin
        t1_diff = {{2{count_one_reg[CNT_W-1]}}, count_one_reg}
                  - $signed({12'd0, s1_item_reg.tick_cycles});
        if (t1_diff < CNT_FLOOR)
        begin
            t1_diff = CNT_FLOOR;
        end
        t1_due = (t1_diff <= 0);
        if (t1_due)
        begin
            if (acr_reg[6])
            begin
                t1_diff = t1_diff + $signed({4'd0, reload_one_reg}) + T1_EXTRA;
            end
            else if (!fired_one_reg)
            begin
                t1_diff = t1_diff + T1_WRAP;
            end
            else
            begin
                t1_diff = {4'd0, t1_diff[15:0]};
            end
        end
    end

    // Timer 2: one-shot only, same wrap once fired
    always_comb
    begin
        t2_diff = {{2{count_two_reg[CNT_W-1]}}, count_two_reg}
                  - $signed({12'd0, s1_item_reg.tick_cycles});
        if (t2_diff < CNT_FLOOR)
        begin
            t2_diff = CNT_FLOOR;
        end
        t2_due = (t2_diff <= 0);
        if (t2_due)
        begin
            if (!fired_two_reg)
            begin
                t2_diff = t2_diff + T1_WRAP;
            end
            else
            begin
                t2_diff = {4'd0, t2_diff[15:0]};
            end
        end
    end

    // Single-pass update of the register state for the held item
    always_comb
    begin
        logic [7:0] v;
        v = s1_item_reg.data_value;

        pins_a_next         = pins_a_reg;
        pins_b_next         = pins_b_reg;
        latch_a_next        = latch_a_reg;
        latch_b_next        = latch_b_reg;
        ora_next            = ora_reg;
        orb_next            = orb_reg;
        ddra_next           = ddra_reg;
        ddrb_next           = ddrb_reg;
        count_one_next      = count_one_reg;
        reload_one_next     = reload_one_reg;
        count_two_next      = count_two_reg;
        reload_two_low_next = reload_two_low_reg;
        fired_one_next      = fired_one_reg;
        fired_two_next      = fired_two_reg;
        flags_next          = flags_reg;
        enables_next        = enables_reg;
        acr_next            = acr_reg;
        pcr_next            = pcr_reg;
        sr_next             = sr_reg;
        ca1_now_next        = ca1_now_reg;
        ca1_before_next     = ca1_before_reg;
        cb1_now_next        = cb1_now_reg;
        cb1_before_next     = cb1_before_reg;
        ca2_next            = ca2_reg;
        cb2_next            = cb2_reg;
        read_data           = 8'd0;

        case (s1_item_reg.op)
            OP_READ:
            begin
                case (s1_item_reg.reg_index)
                    REG_ORB:
                    begin
                        flags_next = flags_reg & ~(FLAG_CB1 | FLAG_CB2);
                        read_data  = latch_b_reg;
                    end
                    REG_ORA:
                    begin
                        flags_next = flags_reg & ~(FLAG_CA1 | FLAG_CA2);
                        read_data  = latch_a_reg;
                    end
                    REG_ORA_NH: read_data = latch_a_reg;
                    REG_DDRB:   read_data = ddrb_reg;
                    REG_DDRA:   read_data = ddra_reg;
                    REG_T1CL:
                    begin
                        flags_next = flags_reg & ~FLAG_T1;
                        read_data  = count_one_reg[7:0];
                    end
                    REG_T1CH:   read_data = count_one_reg[15:8];
                    REG_T1LL:   read_data = reload_one_reg[7:0];
                    REG_T1LH:   read_data = reload_one_reg[15:8];
                    REG_T2CL:
                    begin
                        flags_next = flags_reg & ~FLAG_T2;
                        read_data  = count_two_reg[7:0];
                    end
                    REG_T2CH:   read_data = count_two_reg[15:8];
                    REG_SR:     read_data = sr_reg;
                    REG_ACR:    read_data = acr_reg;
                    REG_PCR:    read_data = pcr_reg;
                    REG_IFR:    read_data = {|(flags_reg & enables_reg), flags_reg};
                    default:    read_data = {1'b1, enables_reg};
                endcase
            end
            OP_WRITE:
            begin
                case (s1_item_reg.reg_index)
                    REG_ORB:
                    begin
                        orb_next     = v;
                        pins_b_next  = (v & ddrb_reg) | (pins_b_reg & ~ddrb_reg);
                        latch_b_next = (pins_b_next & ~ddrb_reg) | (v & ddrb_reg);
                        flags_next   = flags_reg & ~(FLAG_CB1 | FLAG_CB2);
                    end
                    REG_ORA, REG_ORA_NH:
                    begin
                        if (s1_item_reg.reg_index == REG_ORA)
                        begin
                            flags_next = flags_reg & ~(FLAG_CA1 | FLAG_CA2);
                        end
                        ora_next     = v;
                        pins_a_next  = (v & ddra_reg) | (pins_a_reg & ~ddra_reg);
                        latch_a_next = pins_a_next;
                    end
                    REG_DDRB:
                    begin
                        ddrb_next    = v;
                        pins_b_next  = (orb_reg & v) | (pins_b_reg & ~v);
                        latch_b_next = (pins_b_next & ~v) | (orb_reg & v);
                    end
                    REG_DDRA:
                    begin
                        ddra_next    = v;
                        pins_a_next  = (ora_reg & v) | (pins_a_reg & ~v);
                        latch_a_next = pins_a_next;
                    end
                    REG_T1CL, REG_T1LL:
                    begin
                        reload_one_next = {reload_one_reg[15:8], v};
                    end
                    REG_T1CH:
                    begin
                        reload_one_next = {v, reload_one_reg[7:0]};
                        count_one_next  = $signed({2'd0, v, reload_one_reg[7:0]});
                        flags_next      = flags_reg & ~FLAG_T1;
                        fired_one_next  = 1'b0;
                    end
                    REG_T1LH:
                    begin
                        reload_one_next = {v, reload_one_reg[7:0]};
                        flags_next      = flags_reg & ~FLAG_T1;
                    end
                    REG_T2CL: reload_two_low_next = v;
                    REG_T2CH:
                    begin
                        count_two_next = $signed({2'd0, v, reload_two_low_reg});
                        flags_next     = flags_reg & ~FLAG_T2;
                        fired_two_next = 1'b0;
                    end
                    REG_SR:  sr_next  = v;
                    REG_ACR: acr_next = v;
                    REG_PCR:
                    begin
                        pcr_next = v;
                        if (v[3:1] == CTL_MANUAL_LOW)
                        begin
                            ca2_next = 1'b0;
                        end
                        else if (v[3:1] == CTL_MANUAL_HIGH)
                        begin
                            ca2_next = 1'b1;
                        end
                        if (v[7:5] == CTL_MANUAL_LOW)
                        begin
                            cb2_next = 1'b0;
                        end
                        else if (v[7:5] == CTL_MANUAL_HIGH)
                        begin
                            cb2_next = 1'b1;
                        end
                    end
                    REG_IFR: flags_next = flags_reg & ~v[6:0];
                    default:
                    begin
                        // Bit 7 chooses set or clear of the named enables
                        if (v[7])
                        begin
                            enables_next = enables_reg | v[6:0];
                        end
                        else
                        begin
                            enables_next = enables_reg & ~v[6:0];
                        end
                    end
                endcase
            end
            OP_TICK:
            begin
                count_one_next = t1_diff[CNT_W-1:0];
                // Fire timer 1 when its count ran out and it reloads or is unfired
                if (t1_due && (acr_reg[6] || !fired_one_reg))
                begin
                    flags_next     = flags_next | FLAG_T1;
                    fired_one_next = fired_one_reg | !acr_reg[6];
                end
                if (!acr_reg[5])
                begin
                    count_two_next = t2_diff[CNT_W-1:0];
                    if (t2_due && !fired_two_reg)
                    begin
                        flags_next     = flags_next | FLAG_T2;
                        fired_two_next = 1'b1;
                    end
                end
                // Edges on CA1/CB1 are examined at ticks only
                if (ca1_now_reg != ca1_before_reg)
                begin
                    if (pcr_reg[0] == ca1_now_reg)
                    begin
                        flags_next = flags_next | FLAG_CA1;
                    end
                    ca1_before_next = ca1_now_reg;
                end
                if (cb1_now_reg != cb1_before_reg)
                begin
                    if (pcr_reg[4] == cb1_now_reg)
                    begin
                        flags_next = flags_next | FLAG_CB1;
                    end
                    cb1_before_next = cb1_now_reg;
                end
            end
            OP_PINS_A:
            begin
                pins_a_next  = v;
                latch_a_next = v;
            end
            OP_PINS_B:
            begin
                pins_b_next  = v;
                latch_b_next = (v & ~ddrb_reg) | (orb_reg & ddrb_reg);
            end
            OP_CA1:
            begin
                ca1_before_next = ca1_now_reg;
                ca1_now_next    = v[0];
            end
            OP_CB1:
            begin
                cb1_before_next = cb1_now_reg;
                cb1_now_next    = v[0];
            end
            default:
            begin
                read_data = 8'd0;
            end
        endcase
    end

    // Pipeline control and register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            rsp_valid_reg      <= 1'b0;
            pins_a_reg         <= 8'hFF;
            pins_b_reg         <= 8'hFF;
            latch_a_reg        <= 8'hFF;
            latch_b_reg        <= 8'hFF;
            ora_reg            <= 8'd0;
            orb_reg            <= 8'd0;
            ddra_reg           <= 8'd0;
            ddrb_reg           <= 8'd0;
            count_one_reg      <= '0;
            reload_one_reg     <= 16'd0;
            count_two_reg      <= '0;
            reload_two_low_reg <= 8'd0;
            fired_one_reg      <= 1'b0;
            fired_two_reg      <= 1'b0;
            flags_reg          <= 7'd0;
            enables_reg        <= 7'd0;
            acr_reg            <= 8'd0;
            pcr_reg            <= 8'd0;
            sr_reg             <= 8'd0;
            ca1_now_reg        <= 1'b0;
            ca1_before_reg     <= 1'b0;
            cb1_now_reg        <= 1'b0;
            cb1_before_reg     <= 1'b0;
            ca2_reg            <= 1'b0;
            cb2_reg            <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg      <= 1'b1;
                pins_a_reg         <= pins_a_next;
                pins_b_reg         <= pins_b_next;
                latch_a_reg        <= latch_a_next;
                latch_b_reg        <= latch_b_next;
                ora_reg            <= ora_next;
                orb_reg            <= orb_next;
                ddra_reg           <= ddra_next;
                ddrb_reg           <= ddrb_next;
                count_one_reg      <= count_one_next;
                reload_one_reg     <= reload_one_next;
                count_two_reg      <= count_two_next;
                reload_two_low_reg <= reload_two_low_next;
                fired_one_reg      <= fired_one_next;
                fired_two_reg      <= fired_two_next;
                flags_reg          <= flags_next;
                enables_reg        <= enables_next;
                acr_reg            <= acr_next;
                pcr_reg            <= pcr_next;
                sr_reg             <= sr_next;
                ca1_now_reg        <= ca1_now_next;
                ca1_before_reg     <= ca1_before_next;
                cb1_now_reg        <= cb1_now_next;
                cb1_before_reg     <= cb1_before_next;
                ca2_reg            <= ca2_next;
                cb2_reg            <= cb2_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: input item and response
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_item_reg <= req.data;
        end
        if (advance)
        begin
            rsp_item_reg.read_data  <= read_data;
            rsp_item_reg.irq        <= |(flags_next & enables_next);
            rsp_item_reg.port_a_out <= pins_a_next;
            rsp_item_reg.port_b_out <= pins_b_next;
            rsp_item_reg.ca2_out    <= ca2_next;
            rsp_item_reg.cb2_out    <= cb2_next;
        end
    end

endmodule

`default_nettype wire
